// File: hdl/fcs_pkg.sv
package fcs_pkg;

   // default frame store capacity in pixels
   localparam int MAX_PIXELS_DEFAULT = 4096;

   localparam int PIX_W = 8;
   // quotient bits produced by the serial divider, one per cycle
   localparam int QUOT_W = 8;
   // (p - low) * 255 fits in 16 bits, doubled plus range in 18
   localparam int NUM_W = 2 * PIX_W;
   localparam int REM_W = NUM_W + 2;
   localparam int STEP_W = $clog2(QUOT_W);

   // request modes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_DRAIN = 1'b1;

   typedef struct packed {
      logic             mode;
      logic [PIX_W-1:0] pixel_in;
      logic             frame_end;
   } fcs_req_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             last_out;
   } fcs_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DIV
   } fcs_state_type;

endpackage

// File: hdl/fcs_ram.sv
module fcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/frame_contrast_stretch_top.sv
// Min-max contrast stretch of one 8-bit greyscale frame. Load words
// (mode 0) write pixels into the frame store in order and finish in the
// cycle they are taken; busy stays low, so loads can be issued every
// cycle. A load with frame_end closes the frame. Each drain word (mode 1)
// then returns the next stored pixel as round((p-low)*255/(high-low)),
// halves rounded up, with last_out on the final pixel; a flat frame
// gives 0 everywhere. A drain that is taken starts the store read; the
// FETCH state forms the dividend from it, a one-bit-per-cycle restoring
// divider in the DIV state makes the quotient, and the output register
// shows it. busy is high in between and drops in the cycle rsp_strobe
// is shown, so the next word can start right then. The result is flagged
// by rsp_strobe for that single cycle only (rsp_data keeps it until the
// next result) and cannot be held off; the receiver must take it. A drain
// while the frame is open or empty, and a load into a closed frame, are
// dropped with no result. After the last drain the block takes a new frame.
module frame_contrast_stretch_top #(
   parameter int MAX_PIXELS = fcs_pkg::MAX_PIXELS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  fcs_pkg::fcs_req_type req_data,
   output logic                rsp_strobe,
   output fcs_pkg::fcs_rsp_type rsp_data
);

   localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int CW = $clog2(MAX_PIXELS + 1);
   localparam int PW = fcs_pkg::PIX_W;
   localparam int QW = fcs_pkg::QUOT_W;
   localparam int NW = fcs_pkg::NUM_W;
   localparam int RW = fcs_pkg::REM_W;
   localparam int SW = fcs_pkg::STEP_W;

   fcs_pkg::fcs_state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] index_ff, index_in;
   logic [PW-1:0] dark_ff, dark_in;
   logic [PW-1:0] light_ff, light_in;
   logic          closed_ff, closed_in;
   logic          last_ff, last_in;
   logic          flat_ff, flat_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [NW-1:0] dvs_ff, dvs_in;
   logic [QW-1:0] quot_ff, quot_in;
   logic [SW-1:0] step_ff, step_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   fcs_pkg::fcs_rsp_type rsp_data_ff, rsp_data_in;

   logic          wr_en;
   logic          rd_en;
   logic [PW-1:0] rd_data;

   logic          accept;
   logic [PW-1:0] pix_clamp;
   logic [PW-1:0] diff;
   logic [PW-1:0] span;
   logic [NW-1:0] num;
   logic [RW-1:0] trial;
   logic          take;
   logic [QW-1:0] quot_next;

   // busy for the whole drain, until the result word is shown
   assign busy   = (state_ff != fcs_pkg::ST_IDLE);
   assign accept = start && !busy;

   // frame store
   fcs_ram #(
      .WIDTH(PW),
      .DEPTH(MAX_PIXELS)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data(req_data.pixel_in),
      .rd_en  (rd_en),
      .rd_addr(index_ff[AW-1:0]),
      .rd_data(rd_data)
   );

   // dividend forming: clamp, subtract low, times 255, doubled plus range
   always_comb begin
      pix_clamp = rd_data;
      if (pix_clamp < dark_ff) begin
         pix_clamp = dark_ff;
      end
      if (pix_clamp > light_ff) begin
         pix_clamp = light_ff;
      end
      diff = pix_clamp - dark_ff;
      span = light_ff - dark_ff;
      num  = {diff, {PW{1'b0}}} - NW'(diff);
   end

   // one restoring divide step
   always_comb begin
      trial     = rem_ff - RW'(dvs_ff);
      take      = (rem_ff >= RW'(dvs_ff));
      quot_next = {quot_ff[QW-2:0], take};
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      index_in      = index_ff;
      dark_in       = dark_ff;
      light_in      = light_ff;
      closed_in     = closed_ff;
      last_in       = last_ff;
      flat_in       = flat_ff;
      rem_in        = rem_ff;
      dvs_in        = dvs_ff;
      quot_in       = quot_ff;
      step_in       = step_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;

      case (state_ff)
         fcs_pkg::ST_IDLE: begin
            if (accept && req_data.mode == fcs_pkg::MODE_LOAD && !closed_ff) begin
               if (count_ff < CW'(MAX_PIXELS)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
                  if (req_data.pixel_in < dark_ff) begin
                     dark_in = req_data.pixel_in;
                  end
                  if (req_data.pixel_in > light_ff) begin
                     light_in = req_data.pixel_in;
                  end
               end
               if (req_data.frame_end) begin
                  closed_in = 1'b1;
               end
            end else if (accept && req_data.mode == fcs_pkg::MODE_DRAIN && closed_ff
                         && index_ff < count_ff) begin
               rd_en    = 1'b1;
               last_in  = ((index_ff + 1'b1) >= count_ff);
               state_in = fcs_pkg::ST_FETCH;
            end
         end
         fcs_pkg::ST_FETCH: begin
            flat_in  = (light_ff <= dark_ff);
            rem_in   = {1'b0, num, 1'b0} + RW'(span);
            dvs_in   = {span, {PW{1'b0}}};
            quot_in  = '0;
            step_in  = '0;
            state_in = fcs_pkg::ST_DIV;
         end
         fcs_pkg::ST_DIV: begin
            if (take) begin
               rem_in = trial;
            end
            dvs_in  = dvs_ff >> 1;
            quot_in = quot_next;
            step_in = step_ff + 1'b1;
            if (step_ff == SW'(QW - 1)) begin
               rsp_strobe_in         = 1'b1;
               rsp_data_in.pixel_out = flat_ff ? '0 : quot_next;
               rsp_data_in.last_out  = last_ff;
               state_in              = fcs_pkg::ST_IDLE;
               if (last_ff) begin
                  count_in  = '0;
                  index_in  = '0;
                  dark_in   = '1;
                  light_in  = '0;
                  closed_in = 1'b0;
               end else begin
                  index_in = index_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = fcs_pkg::ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fcs_pkg::ST_IDLE;
         count_ff      <= '0;
         index_ff      <= '0;
         dark_ff       <= '1;
         light_ff      <= '0;
         closed_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         index_ff      <= index_in;
         dark_ff       <= dark_in;
         light_ff      <= light_in;
         closed_ff     <= closed_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      flat_ff     <= flat_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      quot_ff     <= quot_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// File: hdl/fcs_checker.sv
module fcs_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input fcs_pkg::fcs_req_type req_data,
   input logic                 rsp_strobe,
   input fcs_pkg::fcs_rsp_type rsp_data
);

   // a word never comes out in two adjacent cycles
   a_single_word: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("fcs: result strobe held two cycles");

   // only a drain makes the block busy
   a_busy_from_drain: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && req_data.mode == fcs_pkg::MODE_DRAIN))
      else $error("fcs: busy without a drain word");

   // busy ends exactly with the result word
   a_busy_ends_with_word: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("fcs: busy dropped without a result");

   // every result follows a busy stretch
   a_word_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) && !busy))
      else $error("fcs: result without divide work");

   // a shown result is fully defined
   a_word_known: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !$isunknown(rsp_data))
      else $error("fcs: result word has unknown bits");

endmodule

bind frame_contrast_stretch_top fcs_checker u_fcs_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_strobe(rsp_strobe),
   .rsp_data  (rsp_data)
);
